@@ design/ifel_pkg.sv @@
// Shared types, constants and command codes of the input frame edge latch.
`default_nettype none

package ifel_pkg;

  // Control table geometry and accumulator width.
  localparam int NUM_CONTROLS = 64;
  localparam int CTRL_AW      = $clog2(NUM_CONTROLS);
  localparam int ACC_WIDTH    = 24;

  // Fixed field widths.
  localparam int MASK_W   = 64;
  localparam int THR_W    = 15;
  localparam int STEP_W   = 24;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 64;

  // Command codes.
  localparam logic [2:0] CMD_BUTTON = 3'd0;
  localparam logic [2:0] CMD_ANALOG = 3'd1;
  localparam logic [2:0] CMD_MOTION = 3'd2;
  localparam logic [2:0] CMD_WHEEL  = 3'd3;
  localparam logic [2:0] CMD_STEP   = 3'd4;
  localparam logic [2:0] CMD_RESET  = 3'd5;
  localparam logic [2:0] CMD_CLEAR  = 3'd6;
  localparam logic [2:0] CMD_QUERY  = 3'd7;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ANALOG_MASK      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_THRESHOLD = 1'd1;

  localparam logic [THR_W-1:0] THRESHOLD_RESET = 15'd16383;

  localparam logic signed [15:0] LEVEL_MAX = 16'sd32767;
  localparam logic signed [15:0] LEVEL_MIN = -16'sd32767;

  typedef logic signed [ACC_WIDTH-1:0] acc_t;
  typedef logic signed [STEP_W-1:0]    step_t;

  typedef struct packed {
    logic [2:0]         command;
    logic [5:0]         control_index;
    logic               button_down;
    logic signed [15:0] analog_value;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] delta_x;
    logic signed [15:0] delta_y;
    logic signed [15:0] wheel_delta;
  } in_t;

  typedef struct packed {
    logic               held;
    logic               pressed;
    logic               released;
    logic               stays_down;
    logic signed [15:0] control_level;
    logic signed [15:0] mouse_x;
    logic signed [15:0] mouse_y;
    step_t              step_dx;
    step_t              step_dy;
    step_t              step_wheel;
  } out_t;

  // Per-control flags as stored in the table, down in the low bit.
  typedef struct packed {
    logic was;
    logic still;
    logic released;
    logic pressed;
    logic held;
    logic redge;
    logic pedge;
    logic down;
  } flags_t;

  typedef struct packed {
    flags_t             flags;
    logic signed [15:0] value;
  } ent_t;

  // Control part of a result, handed from the table engine to the top level.
  typedef struct packed {
    logic               valid;
    logic               held;
    logic               pressed;
    logic               released;
    logic               stays_down;
    logic signed [15:0] level;
  } tbl_res_t;

  // Mouse registers as seen by the result.
  typedef struct packed {
    logic signed [15:0] mouse_x;
    logic signed [15:0] mouse_y;
    step_t              step_dx;
    step_t              step_dy;
    step_t              step_wheel;
  } motion_t;

endpackage

`default_nettype wire

@@ design/ifel_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module ifel_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ design/ifel_motion.sv @@
// Mouse position registers and saturating motion and wheel accumulators.
`default_nettype none

module ifel_motion (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            accept,
  input  wire ifel_pkg::in_t   in_item,
  output ifel_pkg::motion_t    motion
);

  logic signed [15:0] last_x_r, last_x_nxt;
  logic signed [15:0] last_y_r, last_y_nxt;
  ifel_pkg::acc_t     pend_r [3];
  ifel_pkg::acc_t     pend_nxt [3];
  ifel_pkg::acc_t     lat_r [3];
  ifel_pkg::acc_t     lat_nxt [3];

  // Adds a 16-bit delta and clamps the sum to the accumulator range.
  function automatic ifel_pkg::acc_t sat_add(ifel_pkg::acc_t a, logic signed [15:0] d);
    logic signed [ifel_pkg::ACC_WIDTH:0] s;
    ifel_pkg::acc_t r;
    s = (ifel_pkg::ACC_WIDTH+1)'(a) + (ifel_pkg::ACC_WIDTH+1)'(d);
    if (s[ifel_pkg::ACC_WIDTH] != s[ifel_pkg::ACC_WIDTH-1]) begin
      if (s[ifel_pkg::ACC_WIDTH]) begin
        r = {1'b1, {(ifel_pkg::ACC_WIDTH-1){1'b0}}};
      end else begin
        r = {1'b0, {(ifel_pkg::ACC_WIDTH-1){1'b1}}};
      end
    end else begin
      r = s[ifel_pkg::ACC_WIDTH-1:0];
    end
    return r;
  endfunction

  always_comb begin
    last_x_nxt = last_x_r;
    last_y_nxt = last_y_r;
    for (int k = 0; k < 3; k++) begin
      pend_nxt[k] = pend_r[k];
      lat_nxt[k]  = lat_r[k];
    end
    if (accept) begin
      case (in_item.command)
        ifel_pkg::CMD_MOTION: begin
          last_x_nxt  = in_item.pos_x;
          last_y_nxt  = in_item.pos_y;
          pend_nxt[0] = sat_add(pend_r[0], in_item.delta_x);
          pend_nxt[1] = sat_add(pend_r[1], in_item.delta_y);
        end
        ifel_pkg::CMD_WHEEL: begin
          pend_nxt[2] = sat_add(pend_r[2], in_item.wheel_delta);
        end
        ifel_pkg::CMD_STEP: begin
          for (int k = 0; k < 3; k++) begin
            lat_nxt[k]  = pend_r[k];
            pend_nxt[k] = '0;
          end
        end
        ifel_pkg::CMD_RESET: begin
          for (int k = 0; k < 3; k++) begin
            pend_nxt[k] = '0;
          end
        end
        ifel_pkg::CMD_CLEAR: begin
          for (int k = 0; k < 3; k++) begin
            pend_nxt[k] = '0;
            lat_nxt[k]  = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_x_r <= '0;
      last_y_r <= '0;
      for (int k = 0; k < 3; k++) begin
        pend_r[k] <= '0;
        lat_r[k]  <= '0;
      end
    end else begin
      last_x_r <= last_x_nxt;
      last_y_r <= last_y_nxt;
      for (int k = 0; k < 3; k++) begin
        pend_r[k] <= pend_nxt[k];
        lat_r[k]  <= lat_nxt[k];
      end
    end
  end

  assign motion.mouse_x    = last_x_r;
  assign motion.mouse_y    = last_y_r;
  assign motion.step_dx    = ifel_pkg::STEP_W'(lat_r[0]);
  assign motion.step_dy    = ifel_pkg::STEP_W'(lat_r[1]);
  assign motion.step_wheel = ifel_pkg::STEP_W'(lat_r[2]);

endmodule

`default_nettype wire

@@ design/ifel_table.sv @@
// Control table engine: read-modify-write of single entries and whole-table sweeps.
`default_nettype none

module ifel_table (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire ifel_pkg::in_t                in_item,
  input  wire logic [ifel_pkg::MASK_W-1:0]  analog_mask,
  input  wire logic [ifel_pkg::THR_W-1:0]   active_threshold,
  output logic                              busy,
  output ifel_pkg::tbl_res_t                res
);

  typedef enum logic [5:0] {
    S_INIT  = 6'b000001,
    S_IDLE  = 6'b000010,
    S_SWEEP = 6'b000100,
    S_FLUSH = 6'b001000,
    S_FETCH = 6'b010000,
    S_MOD   = 6'b100000
  } tbl_state_t;

  localparam int AW = ifel_pkg::CTRL_AW;
  localparam logic [AW-1:0] LAST_ADDR = AW'(ifel_pkg::NUM_CONTROLS - 1);

  tbl_state_t         state_r, state_nxt;
  logic [AW-1:0]      cnt_r, cnt_nxt;
  logic               wr_pend_r, wr_pend_nxt;
  logic [AW-1:0]      wr_addr_r, wr_addr_nxt;
  logic [2:0]         cmd_r, cmd_nxt;
  logic [5:0]         idx_r, idx_nxt;
  logic               down_r, down_nxt;
  logic signed [15:0] val_r, val_nxt;

  logic               accept;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  ifel_pkg::ent_t     ram_wdata;
  logic [AW-1:0]      ram_raddr;
  ifel_pkg::ent_t     ram_rdata;
  logic [$bits(ifel_pkg::ent_t)-1:0] ram_rbits;

  logic               idx_inrange;
  logic [AW-1:0]      idx_addr;
  ifel_pkg::ent_t     mod_ent;

  function automatic logic is_analog(logic [ifel_pkg::MASK_W-1:0] mask, logic [AW-1:0] a);
    logic [ifel_pkg::MASK_W-1:0] sh;
    sh = mask >> a;
    return (32'(a) < ifel_pkg::MASK_W) && sh[0];
  endfunction

  // New state of one entry under a table-wide command.
  function automatic ifel_pkg::ent_t sweep_entry(ifel_pkg::ent_t e, logic [2:0] cmd,
                                                 logic analog, logic [ifel_pkg::THR_W-1:0] thr);
    ifel_pkg::ent_t r;
    logic           active;
    r      = e;
    active = e.value > $signed({1'b0, thr});
    case (cmd)
      ifel_pkg::CMD_STEP: begin
        if (analog) begin
          r.flags          = '0;
          r.flags.down     = e.flags.down;
          r.flags.held     = active;
          r.flags.still    = active;
          r.flags.was      = active;
          r.flags.pressed  = active && !e.flags.was;
          r.flags.released = !active && e.flags.was;
        end else begin
          r.flags.pedge    = 1'b0;
          r.flags.redge    = 1'b0;
          r.flags.pressed  = e.flags.pedge;
          r.flags.released = e.flags.redge;
          r.flags.held     = e.flags.down || e.flags.pedge;
          r.flags.still    = e.flags.down;
        end
      end
      ifel_pkg::CMD_RESET: begin
        r.flags.redge = e.flags.redge || e.flags.down;
        r.flags.down  = 1'b0;
        r.value       = '0;
      end
      ifel_pkg::CMD_CLEAR: begin
        r.flags       = '0;
        r.flags.down  = e.flags.down;
        r.flags.was   = e.flags.was;
        r.flags.held  = e.flags.down;
        r.flags.still = e.flags.down;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  assign accept      = start && (state_r == S_IDLE);
  assign busy        = (state_r != S_IDLE);
  assign idx_inrange = 32'(idx_r) < ifel_pkg::NUM_CONTROLS;
  assign idx_addr    = AW'(idx_r);
  assign ram_rdata   = ifel_pkg::ent_t'(ram_rbits);

  ifel_ram #(
    .WIDTH ($bits(ifel_pkg::ent_t)),
    .DEPTH (ifel_pkg::NUM_CONTROLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rbits)
  );

  // Single-entry update for button and analog events.
  always_comb begin
    mod_ent = ram_rdata;
    if (cmd_r == ifel_pkg::CMD_BUTTON) begin
      if (down_r && !ram_rdata.flags.down) begin
        mod_ent.flags.pedge = 1'b1;
      end
      if (!down_r && ram_rdata.flags.down) begin
        mod_ent.flags.redge = 1'b1;
      end
      mod_ent.flags.down = down_r;
    end else if (cmd_r == ifel_pkg::CMD_ANALOG) begin
      mod_ent.value = val_r;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    wr_pend_nxt = 1'b0;
    wr_addr_nxt = wr_addr_r;
    cmd_nxt     = cmd_r;
    idx_nxt     = idx_r;
    down_nxt    = down_r;
    val_nxt     = val_r;
    ram_we      = 1'b0;
    ram_waddr   = wr_addr_r;
    ram_wdata   = sweep_entry(ram_rdata, cmd_r, is_analog(analog_mask, wr_addr_r),
                              active_threshold);
    ram_raddr   = AW'(in_item.control_index);
    res         = '0;

    case (state_r)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r;
        ram_wdata = '0;
        if (cnt_r == LAST_ADDR) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd_nxt  = in_item.command;
          idx_nxt  = in_item.control_index;
          down_nxt = in_item.button_down;
          val_nxt  = (in_item.analog_value < ifel_pkg::LEVEL_MIN) ?
                     ifel_pkg::LEVEL_MIN : in_item.analog_value;
          if (in_item.command inside {ifel_pkg::CMD_STEP, ifel_pkg::CMD_RESET,
                                      ifel_pkg::CMD_CLEAR}) begin
            cnt_nxt   = '0;
            state_nxt = S_SWEEP;
          end else begin
            state_nxt = S_MOD;
          end
        end
      end
      S_SWEEP: begin
        // Read one entry a cycle; the entry read last cycle is written back now.
        ram_raddr   = cnt_r;
        ram_we      = wr_pend_r;
        wr_pend_nxt = 1'b1;
        wr_addr_nxt = cnt_r;
        if (cnt_r == LAST_ADDR) begin
          cnt_nxt   = '0;
          state_nxt = S_FLUSH;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_FLUSH: begin
        ram_raddr = idx_addr;
        ram_we    = wr_pend_r;
        state_nxt = S_FETCH;
      end
      S_FETCH: begin
        ram_raddr = idx_addr;
        state_nxt = S_MOD;
      end
      S_MOD: begin
        ram_waddr = idx_addr;
        ram_wdata = mod_ent;
        ram_we    = idx_inrange &&
                    ((cmd_r == ifel_pkg::CMD_BUTTON) || (cmd_r == ifel_pkg::CMD_ANALOG));
        res.valid = 1'b1;
        if (idx_inrange) begin
          res.held       = mod_ent.flags.held;
          res.pressed    = mod_ent.flags.pressed;
          res.released   = mod_ent.flags.released;
          res.stays_down = mod_ent.flags.still;
          if (is_analog(analog_mask, idx_addr)) begin
            res.level = mod_ent.value;
          end else begin
            res.level = mod_ent.flags.held ? ifel_pkg::LEVEL_MAX : '0;
          end
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_INIT;
      cnt_r     <= '0;
      wr_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      wr_pend_r <= wr_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wr_addr_r <= wr_addr_nxt;
    cmd_r     <= cmd_nxt;
    idx_r     <= idx_nxt;
    down_r    <= down_nxt;
    val_r     <= val_nxt;
  end

  // The table is never written while waiting for a command.
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !ram_we)
    else $error("table written while idle");

  // The flush cycle writes back exactly the last entry of the sweep.
  a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FLUSH) |-> (wr_pend_r && (wr_addr_r == LAST_ADDR)))
    else $error("sweep flush does not complete the last entry");

  // Every sweep cycle after the first has a pending write-back.
  a_sweep_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_SWEEP) && (cnt_r != '0)) |-> wr_pend_r)
    else $error("sweep lost a write-back");

  // A result is produced only in the cycle after the entry was read.
  a_res_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> ($past(state_r == S_IDLE) || $past(state_r == S_FETCH)))
    else $error("result without a preceding table read");

endmodule

`default_nettype wire

@@ design/input_frame_edge_latch_core.sv @@
// Top level of the input frame edge latch: ports, configuration registers, result register.
//
// Usage. A command beat is taken on in_item at a rising edge where start is high
// and busy is low. Button and analog events update one entry of the control table,
// motion and wheel events feed saturating accumulators, and step, reset and
// clear-edges act on every control. Every command beat answers with exactly one
// result beat on out_item, marked by out_valid for a single cycle; the result holds
// the flags and level of the addressed control and the mouse registers, all as
// they stand after the command has taken effect. The receiver cannot stall: a
// result is gone after its one cycle.
// Command flow. Button, analog, motion, wheel and query commands read the table entry in the
// accept cycle; in the next one the result is formed and registered onto out_item, and button
// and analog commands write the entry back. busy stays high through that cycle, so a new
// command is taken only after it. Step, reset and clear-edges walk the table through its read
// and write ports at one entry per cycle, then flush the last write-back and fetch the entry.
// Reset. After rst_n is released the table is cleared by one pass over all NUM_CONTROLS
// entries, during which busy stays high. Configuration beats on the cfg_ channel are
// always taken, also during that pass, and apply to the following commands; the sender
// must write them only while no command is in flight, which the block does not enforce.
`default_nettype none

module input_frame_edge_latch_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire ifel_pkg::in_t                     in_item,
  output logic                                   out_valid,
  output ifel_pkg::out_t                         out_item,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [ifel_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [ifel_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [ifel_pkg::MASK_W-1:0] analog_mask_r, analog_mask_nxt;
  logic [ifel_pkg::THR_W-1:0]  threshold_r, threshold_nxt;
  logic                        out_valid_r, out_valid_nxt;
  ifel_pkg::out_t              out_r, out_nxt;

  logic                        accept;
  ifel_pkg::tbl_res_t          tbl_res;
  ifel_pkg::motion_t           motion;

  // The configuration beat is accepted unconditionally.
  assign cfg_ready = 1'b1;

  // A command beat is taken only when the table engine is waiting.
  assign accept = start && !busy;

  ifel_table u_table (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .in_item          (in_item),
    .analog_mask      (analog_mask_r),
    .active_threshold (threshold_r),
    .busy             (busy),
    .res              (tbl_res)
  );

  // Mouse registers update in the accept cycle, before the result is formed.
  ifel_motion u_motion (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_item (in_item),
    .motion  (motion)
  );

  always_comb begin
    analog_mask_nxt = analog_mask_r;
    threshold_nxt   = threshold_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ifel_pkg::REG_ANALOG_MASK: begin
          analog_mask_nxt = cfg_data[ifel_pkg::MASK_W-1:0];
        end
        ifel_pkg::REG_ACTIVE_THRESHOLD: begin
          threshold_nxt = cfg_data[ifel_pkg::THR_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // The result register joins the control part from the table with the mouse part.
  always_comb begin
    out_valid_nxt = tbl_res.valid;
    out_nxt       = out_r;
    if (tbl_res.valid) begin
      out_nxt.held          = tbl_res.held;
      out_nxt.pressed       = tbl_res.pressed;
      out_nxt.released      = tbl_res.released;
      out_nxt.stays_down    = tbl_res.stays_down;
      out_nxt.control_level = tbl_res.level;
      out_nxt.mouse_x       = motion.mouse_x;
      out_nxt.mouse_y       = motion.mouse_y;
      out_nxt.step_dx       = motion.step_dx;
      out_nxt.step_dy       = motion.step_dy;
      out_nxt.step_wheel    = motion.step_wheel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      analog_mask_r <= '0;
      threshold_r   <= ifel_pkg::THRESHOLD_RESET;
      out_valid_r   <= 1'b0;
    end else begin
      analog_mask_r <= analog_mask_nxt;
      threshold_r   <= threshold_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the input frame edge latch: directed table, then random phases.
module tb_top;
  import ifel_pkg::*;

  // The watchdog ends the run when no beat of any kind moves for this many cycles.
  // The slowest legal stretch is a long sender gap followed by a full table walk,
  // far shorter than QUIET_LIMIT, so this leaves a wide margin.
  localparam int QUIET_LIMIT = 2000;
  // Cycles to linger after the last expected result, longer than one table walk.
  localparam int TAIL_CYCLES = 80;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  in_t                   in_item;
  logic                  out_valid;
  out_t                  out_item;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  input_frame_edge_latch_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the block's state, kept up to date as command beats are accepted.
  flags_t             ctl_flags [NUM_CONTROLS];
  logic signed [15:0] ctl_value [NUM_CONTROLS];
  logic signed [15:0] mouse_at_x;
  logic signed [15:0] mouse_at_y;
  acc_t               motion_pend [3];
  acc_t               motion_step [3];
  logic [MASK_W-1:0]  mask_now;
  logic [THR_W-1:0]   thr_now;

  // Readbacks the block still owes, oldest first.
  out_t due_readbacks [$];
  out_t oldest;
  int   mismatches;
  int   quiet_cycles;

  // Stimulus shaping knobs, changed per phase.
  bit gappy;
  bit sat_mode;

  // One row of the directed table. A typed row carries its readback written out by
  // hand; every other row is checked against the shadow model.
  typedef struct {
    in_t  cmd_beat;
    bit   typed;
    out_t want;
  } dir_row_t;

  dir_row_t directed [$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Saturating add into a pending motion accumulator.
  function automatic acc_t sat_add(acc_t a, logic signed [15:0] d);
    int s;
    int hi;
    hi = (1 << (ACC_WIDTH - 1)) - 1;
    s = int'(a) + int'(d);
    if (s > hi) begin
      s = hi;
    end else if (s < -hi - 1) begin
      s = -hi - 1;
    end
    return acc_t'(s);
  endfunction

  // Applies one accepted command beat to the shadow state and returns the readback
  // the block must produce for it: the addressed control and the mouse registers,
  // as they stand after the command has taken effect.
  function automatic out_t next_readback(in_t b);
    flags_t f;
    flags_t nf;
    out_t   r;
    bit     active;
    f = '0;
    r = '0;
    case (b.command)
      CMD_BUTTON: begin
        // Only a change of the down state leaves a sticky edge behind.
        f = ctl_flags[b.control_index];
        if (b.button_down && !f.down) f.pedge = 1'b1;
        if (!b.button_down && f.down) f.redge = 1'b1;
        f.down = b.button_down;
        ctl_flags[b.control_index] = f;
      end
      CMD_ANALOG: begin
        // The most negative reading is pulled in so the range is symmetric.
        ctl_value[b.control_index] = (b.analog_value == 16'sh8000) ? LEVEL_MIN : b.analog_value;
      end
      CMD_MOTION: begin
        mouse_at_x = b.pos_x;
        mouse_at_y = b.pos_y;
        motion_pend[0] = sat_add(motion_pend[0], b.delta_x);
        motion_pend[1] = sat_add(motion_pend[1], b.delta_y);
      end
      CMD_WHEEL: begin
        motion_pend[2] = sat_add(motion_pend[2], b.wheel_delta);
      end
      CMD_STEP: begin
        for (int i = 0; i < NUM_CONTROLS; i++) begin
          f = ctl_flags[i];
          nf = '0;
          nf.down = f.down;
          if (mask_now[i]) begin
            // Analog controls derive their step flags from the threshold and the
            // was-active mark; button edges on them are simply dropped.
            active = int'(ctl_value[i]) > int'(thr_now);
            if (active) begin
              nf.held = 1'b1;
              nf.still = 1'b1;
              nf.was = 1'b1;
            end
            if (active && !f.was) nf.pressed = 1'b1;
            if (!active && f.was) nf.released = 1'b1;
          end else begin
            nf.was = f.was;
            nf.pressed = f.pedge;
            nf.released = f.redge;
            nf.held = f.down | f.pedge;
            nf.still = f.down;
          end
          ctl_flags[i] = nf;
        end
        motion_step = motion_pend;
        motion_pend = '{default: '0};
      end
      CMD_RESET: begin
        for (int i = 0; i < NUM_CONTROLS; i++) begin
          if (ctl_flags[i].down) ctl_flags[i].redge = 1'b1;
          ctl_flags[i].down = 1'b0;
          ctl_value[i] = '0;
        end
        motion_pend = '{default: '0};
      end
      CMD_CLEAR: begin
        for (int i = 0; i < NUM_CONTROLS; i++) begin
          nf = '0;
          nf.down = ctl_flags[i].down;
          nf.was = ctl_flags[i].was;
          nf.held = nf.down;
          nf.still = nf.down;
          ctl_flags[i] = nf;
        end
        motion_pend = '{default: '0};
        motion_step = '{default: '0};
      end
      default: begin
      end
    endcase

    f = ctl_flags[b.control_index];
    r.held = f.held;
    r.pressed = f.pressed;
    r.released = f.released;
    r.stays_down = f.still;
    if (mask_now[b.control_index]) begin
      r.control_level = ctl_value[b.control_index];
    end else begin
      r.control_level = f.held ? LEVEL_MAX : 16'sd0;
    end
    r.mouse_x = mouse_at_x;
    r.mouse_y = mouse_at_y;
    r.step_dx = motion_step[0];
    r.step_dy = motion_step[1];
    r.step_wheel = motion_step[2];
    return r;
  endfunction

  // Builds a command beat; a goes to the analog, x, x-motion and wheel fields, c to
  // the y fields, so one row exercises whichever fields its command uses.
  function automatic in_t beat(logic [2:0] cmd, int idx, bit down,
                               logic signed [15:0] a, logic signed [15:0] c);
    in_t x;
    x.command = cmd;
    x.control_index = 6'(idx);
    x.button_down = down;
    x.analog_value = a;
    x.pos_x = a;
    x.pos_y = c;
    x.delta_x = a;
    x.delta_y = c;
    x.wheel_delta = a;
    return x;
  endfunction

  // Appends a directed row. A typed row expects all zero apart from its level.
  function automatic void add_row(in_t b, bit typed, logic signed [15:0] level);
    dir_row_t row;
    row.cmd_beat = b;
    row.typed = typed;
    row.want = '0;
    row.want.control_level = level;
    directed.insert(directed.size(), row);
  endfunction

  // Random 16-bit field value with the extremes weighted up.
  function automatic logic signed [15:0] rand16();
    case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return 16'shffff;
      default: return 16'($urandom);
    endcase
  endfunction

  // Most beats land on a few controls at both ends of the table so that press,
  // step and release sequences build up on them; the rest go anywhere.
  function automatic int pick_index();
    int k;
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, NUM_CONTROLS - 1);
    k = $urandom_range(0, 7);
    return (k < 4) ? k : NUM_CONTROLS - 8 + k;
  endfunction

  function automatic in_t random_beat();
    in_t b;
    int  r;
    b.command = 3'($urandom);
    b.control_index = 6'(pick_index());
    b.button_down = 1'($urandom);
    b.analog_value = rand16();
    b.pos_x = rand16();
    b.pos_y = rand16();
    b.delta_x = rand16();
    b.delta_y = rand16();
    b.wheel_delta = rand16();
    r = $urandom_range(0, 99);
    if (sat_mode) begin
      // Drive the accumulators into their rails: x upward, y and wheel downward.
      if (r < 45) begin
        b.command = CMD_MOTION;
        b.delta_x = 16'sh7fff - 16'($urandom_range(0, 3));
        b.delta_y = 16'sh8000 + 16'($urandom_range(0, 3));
      end else if (r < 88) begin
        b.command = CMD_WHEEL;
        b.wheel_delta = 16'sh8000 + 16'($urandom_range(0, 3));
      end else if (r < 95) begin
        b.command = CMD_QUERY;
      end else begin
        b.command = CMD_BUTTON;
      end
    end else begin
      if (r < 28) b.command = CMD_BUTTON;
      else if (r < 43) b.command = CMD_ANALOG;
      else if (r < 56) b.command = CMD_MOTION;
      else if (r < 66) b.command = CMD_WHEEL;
      else if (r < 80) b.command = CMD_STEP;
      else if (r < 83) b.command = CMD_RESET;
      else if (r < 86) b.command = CMD_CLEAR;
      else b.command = CMD_QUERY;
      // A third of the analog readings sit at the threshold or one away from it.
      if (b.command == CMD_ANALOG && $urandom_range(0, 2) == 0) begin
        b.analog_value = 16'(int'(thr_now) + $urandom_range(0, 2) - 1);
      end
    end
    return b;
  endfunction

  // Sender gap ahead of the next beat: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    if (!gappy) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Writes both configuration registers back to back and mirrors them in the model.
  // The spare upper data bits of the threshold beat carry junk that must be dropped.
  task automatic program_regs(input logic [MASK_W-1:0] mask, input logic [THR_W-1:0] thr);
    cfg_valid <= 1'b1;
    cfg_index <= REG_ANALOG_MASK;
    cfg_data <= mask;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= REG_ACTIVE_THRESHOLD;
    cfg_data <= {17'($urandom), 32'($urandom), thr};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    mask_now = mask;
    thr_now = thr;
  endtask

  // Offers one command beat and waits until it is taken. Start stays high on return,
  // so a following beat with no gap goes out on the very next cycle; a gap lowers
  // start and puts junk on the payload in the meantime.
  task automatic issue(input in_t b, input bit typed, input out_t want, input int gap);
    out_t predicted;
    if (gap > 0) begin
      start <= 1'b0;
      in_item <= random_beat();
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = next_readback(b);
    due_readbacks.insert(due_readbacks.size(), typed ? want : predicted);
  endtask

  // Lowers start and waits until every owed readback has come back.
  task automatic drain();
    start <= 1'b0;
    while (due_readbacks.size() != 0) @(posedge clk);
  endtask

  function automatic void compare_field(string name, logic [23:0] want, logic [23:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  // Result checker. The receiver cannot stall, so every strobe is one readback.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (due_readbacks.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with nothing expected, expected none, actual %h",
                 $time, out_item);
      end else begin
        oldest = due_readbacks.pop_front();
        compare_field("held", oldest.held, out_item.held);
        compare_field("pressed", oldest.pressed, out_item.pressed);
        compare_field("released", oldest.released, out_item.released);
        compare_field("stays_down", oldest.stays_down, out_item.stays_down);
        compare_field("control_level", oldest.control_level, out_item.control_level);
        compare_field("mouse_x", oldest.mouse_x, out_item.mouse_x);
        compare_field("mouse_y", oldest.mouse_y, out_item.mouse_y);
        compare_field("step_dx", oldest.step_dx, out_item.step_dx);
        compare_field("step_dy", oldest.step_dy, out_item.step_dy);
        compare_field("step_wheel", oldest.step_wheel, out_item.step_wheel);
      end
    end
  end

  // Watchdog: any accepted command, result or configuration beat counts as progress.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int items;
    // Every input gets a known value before the first edge.
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    quiet_cycles = 0;
    mismatches = 0;
    gappy = 1'b1;
    sat_mode = 1'b0;
    for (int i = 0; i < NUM_CONTROLS; i++) begin
      ctl_flags[i] = '0;
      ctl_value[i] = '0;
    end
    mouse_at_x = '0;
    mouse_at_y = '0;
    motion_pend = '{default: '0};
    motion_step = '{default: '0};
    mask_now = '0;
    thr_now = THRESHOLD_RESET;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: controls 0 and 63 are analog, the threshold keeps its reset value.
    program_regs(64'h8000_0000_0000_0001, THRESHOLD_RESET);

    // A query straight after reset reads all zero.
    add_row(beat(CMD_QUERY, 5, 1'b0, 16'sh0, 16'sh0), 1'b1, 16'sd0);
    // The most negative analog reading is clamped one step up.
    add_row(beat(CMD_ANALOG, 0, 1'b0, 16'sh8000, 16'sh0), 1'b1, LEVEL_MIN);
    // Press and release of a digital control across two steps.
    add_row(beat(CMD_BUTTON, 5, 1'b1, 16'sh0, 16'sh0), 1'b0, 16'sd0);
    add_row(beat(CMD_STEP, 5, 1'b0, 16'sh0, 16'sh0), 1'b0, 16'sd0);
    add_row(beat(CMD_BUTTON, 5, 1'b0, 16'sh0, 16'sh0), 1'b0, 16'sd0);
    add_row(beat(CMD_STEP, 5, 1'b0, 16'sh0, 16'sh0), 1'b0, 16'sd0);
    // Analog control at the top of the table: full scale, then exactly at threshold.
    add_row(beat(CMD_ANALOG, 63, 1'b0, 16'sh7fff, 16'sh0), 1'b0, 16'sd0);
    add_row(beat(CMD_STEP, 63, 1'b0, 16'sh0, 16'sh0), 1'b0, 16'sd0);
    add_row(beat(CMD_STEP, 63, 1'b0, 16'sh0, 16'sh0), 1'b0, 16'sd0);
    add_row(beat(CMD_ANALOG, 63, 1'b0, 16'sd16383, 16'sh0), 1'b0, 16'sd0);
    add_row(beat(CMD_STEP, 63, 1'b0, 16'sh0, 16'sh0), 1'b0, 16'sd0);
    // A button event on an analog control must not leak into its step flags.
    add_row(beat(CMD_ANALOG, 0, 1'b0, 16'sd16384, 16'sh0), 1'b0, 16'sd0);
    add_row(beat(CMD_BUTTON, 0, 1'b1, 16'sh0, 16'sh0), 1'b0, 16'sd0);
    add_row(beat(CMD_STEP, 0, 1'b0, 16'sh0, 16'sh0), 1'b0, 16'sd0);
    // An analog value stored on a digital control stays hidden.
    add_row(beat(CMD_ANALOG, 7, 1'b0, 16'sd1234, 16'sh0), 1'b0, 16'sd0);
    add_row(beat(CMD_QUERY, 7, 1'b0, 16'sh0, 16'sh0), 1'b0, 16'sd0);
    // Motion and wheel at their extremes, then latched by a step.
    add_row(beat(CMD_MOTION, 0, 1'b0, 16'sh7fff, 16'sh8000), 1'b0, 16'sd0);
    add_row(beat(CMD_MOTION, 0, 1'b1, 16'sh7fff, 16'sh8000), 1'b0, 16'sd0);
    add_row(beat(CMD_WHEEL, 0, 1'b0, 16'sh7fff, 16'sh0), 1'b0, 16'sd0);
    add_row(beat(CMD_WHEEL, 0, 1'b0, 16'sh8000, 16'sh0), 1'b0, 16'sd0);
    add_row(beat(CMD_STEP, 1, 1'b0, 16'sh0, 16'sh0), 1'b0, 16'sd0);
    // Reset while a control is down leaves a release edge behind.
    add_row(beat(CMD_BUTTON, 9, 1'b1, 16'sh0, 16'sh0), 1'b0, 16'sd0);
    add_row(beat(CMD_RESET, 9, 1'b0, 16'sh0, 16'sh0), 1'b0, 16'sd0);
    add_row(beat(CMD_STEP, 9, 1'b0, 16'sh0, 16'sh0), 1'b0, 16'sd0);
    // Clear-edges with a control held down: held and still-down follow down.
    add_row(beat(CMD_BUTTON, 9, 1'b1, 16'sh0, 16'sh0), 1'b0, 16'sd0);
    add_row(beat(CMD_CLEAR, 9, 1'b0, 16'sh0, 16'sh0), 1'b0, 16'sd0);

    foreach (directed[k]) begin
      issue(directed[k].cmd_beat, directed[k].typed, directed[k].want, pick_gap());
    end

    // Random phases. Each starts idle with a fresh configuration, the extremes among
    // them; one phase runs with no gaps at all, and the last one pushes the motion
    // and wheel accumulators into saturation before a single step latches them.
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: program_regs({$urandom, $urandom}, 15'($urandom));
        1: program_regs('1, 15'd0);
        2: program_regs('0, 15'h7fff);
        3: program_regs({$urandom, $urandom}, 15'h7fff);
        4: program_regs('1, 15'($urandom));
        default: program_regs({$urandom, $urandom}, 15'd0);
      endcase
      gappy = (ph != 2);
      sat_mode = (ph == 5);
      items = sat_mode ? 600 : 150;
      for (int n = 0; n < items; n++) begin
        issue(random_beat(), 1'b0, '0, pick_gap());
      end
    end
    sat_mode = 1'b0;
    issue(beat(CMD_STEP, 0, 1'b0, 16'sh0, 16'sh0), 1'b0, '0, pick_gap());
    issue(beat(CMD_QUERY, 63, 1'b0, 16'sh0, 16'sh0), 1'b0, '0, pick_gap());

    // Wait out every owed readback, then linger to catch any stray result beat.
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
